// File: hdl/ptrk_pkg.sv
// ----------------------------------------------------------------------------
// Peak tracker package
// Shared sizes, reset constants and types for the resonance peak tracker.
// ----------------------------------------------------------------------------
package ptrk_pkg;

    localparam int NUM_PERIODS = 1024;
    localparam int IDX_W       = $clog2(NUM_PERIODS);
    localparam int CUR_W       = 32;
    localparam int PER_W       = 16;
    localparam int BEST_W      = 10;

    localparam logic [IDX_W-1:0] LAST_IDX            = IDX_W'(NUM_PERIODS - 1);
    localparam logic [CUR_W-1:0] RESET_STEP          = 32'd4096000;
    localparam logic [CUR_W-1:0] FAULT_CURRENT       = 32'd1;
    localparam logic [PER_W-1:0] LOWEST_PERIOD_RESET = 16'd3000;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } ptrk_state_t;

    typedef struct packed {
        logic             clear;
        logic             sample;
        logic [IDX_W-1:0] index;
    } ptrk_scan_ctl_t;

endpackage

// File: hdl/ptrk_table.sv
// ----------------------------------------------------------------------------
// Current table
// One current per candidate period, one write port and one registered read.
// ----------------------------------------------------------------------------
module ptrk_table
    import ptrk_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [CUR_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [CUR_W-1:0] rd_data
);

    logic [CUR_W-1:0] mem [NUM_PERIODS];
    logic [CUR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/ptrk_scan.sv
// ----------------------------------------------------------------------------
// Maximum scanner
// Walks the table read data and keeps the first strict maximum and its index.
// ----------------------------------------------------------------------------
module ptrk_scan
    import ptrk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ptrk_scan_ctl_t   ctl,
    input  logic [CUR_W-1:0] rd_data,
    output logic [CUR_W-1:0] top,
    output logic [IDX_W-1:0] where
);

    logic [CUR_W-1:0] top_reg;
    logic [CUR_W-1:0] top_next;
    logic [IDX_W-1:0] where_reg;
    logic [IDX_W-1:0] where_next;

    always_comb
    begin
        top_next   = top_reg;
        where_next = where_reg;
        if (ctl.clear)
        begin
            top_next   = '0;
            where_next = '0;
        end
        else if (ctl.sample && (rd_data > top_reg))
        begin
            top_next   = rd_data;
            where_next = ctl.index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            where_reg <= '0;
        end
        else
        begin
            top_reg   <= top_next;
            where_reg <= where_next;
        end
    end

    assign top   = top_reg;
    assign where = where_reg;

endmodule

// File: hdl/resonance_peak_tracker.sv
// ----------------------------------------------------------------------------
// Resonance peak tracker
// Stores each current or fault value at the period in use, then scans
// the table for the first strict maximum and reports the period to use next.
// After an input transfer the whole table is read in order, the last read
// is awaited and the result is registered. No new input is taken until
// then, as the scan goes through the single read port.
// Reset: a clearing pass over all NUM_PERIODS entries loads the table with
// rising currents; no input is taken until it ends. Config is taken always.
// ----------------------------------------------------------------------------
module resonance_peak_tracker
    import ptrk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [PER_W-1:0] lowest_period,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             action,
    input  logic [CUR_W-1:0] rms_current,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PER_W-1:0] period,
    output logic [BEST_W-1:0] best_index,
    output logic             period_changed,
    output logic [CUR_W-1:0] peak_current
);

    ptrk_state_t      state_reg;
    ptrk_state_t      state_next;
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] addr_next;
    logic [CUR_W-1:0] init_val_reg;
    logic [CUR_W-1:0] init_val_next;
    logic [PER_W-1:0] lowest_period_reg;
    logic [IDX_W-1:0] best_entry_reg;
    logic [IDX_W-1:0] best_entry_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] rd_idx_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PER_W-1:0] period_reg;
    logic [PER_W-1:0] period_next;
    logic [BEST_W-1:0] best_index_reg;
    logic [BEST_W-1:0] best_index_next;
    logic             changed_reg;
    logic             changed_next;
    logic [CUR_W-1:0] peak_reg;
    logic [CUR_W-1:0] peak_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CUR_W-1:0] wr_data;
    logic             rd_en;
    logic [CUR_W-1:0] rd_data;
    logic             in_xfer;
    ptrk_scan_ctl_t   scan_ctl;
    logic [CUR_W-1:0] scan_top;
    logic [IDX_W-1:0] scan_where;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        init_val_next   = init_val_reg;
        best_entry_next = best_entry_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        period_next     = period_reg;
        best_index_next = best_index_reg;
        changed_next    = changed_reg;
        peak_next       = peak_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = init_val_reg;
        rd_en           = 1'b0;
        scan_ctl.clear  = 1'b0;
        scan_ctl.sample = rd_pend_reg;
        scan_ctl.index  = rd_idx_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                addr_next     = addr_reg + 1'b1;
                init_val_next = init_val_reg + RESET_STEP;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = best_entry_reg;
                    wr_data        = action ? FAULT_CURRENT : rms_current;
                    addr_next      = '0;
                    scan_ctl.clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_en        = 1'b1;
                rd_pend_next = 1'b1;
                addr_next    = addr_reg + 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    period_next     = PER_W'(scan_where) + lowest_period_reg;
                    best_index_next = BEST_W'(scan_where);
                    changed_next    = (scan_where != best_entry_reg);
                    peak_next       = scan_top;
                    best_entry_next = scan_where;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            addr_reg          <= '0;
            init_val_reg      <= RESET_STEP;
            lowest_period_reg <= LOWEST_PERIOD_RESET;
            best_entry_reg    <= '0;
            rd_pend_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            init_val_reg   <= init_val_next;
            best_entry_reg <= best_entry_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                lowest_period_reg <= lowest_period;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        period_reg     <= period_next;
        best_index_reg <= best_index_next;
        changed_reg    <= changed_next;
        peak_reg       <= peak_next;
    end

    ptrk_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    ptrk_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .rd_data (rd_data),
        .top     (scan_top),
        .where   (scan_where)
    );

    assign out_valid      = out_valid_reg;
    assign period         = period_reg;
    assign best_index     = best_index_reg;
    assign period_changed = changed_reg;
    assign peak_current   = peak_reg;

endmodule

// File: test/tb_resonance_peak_tracker.sv
// ----------------------------------------------------------------------------
// Resonance peak tracker testbench
// Feeds measurement and fault transfers through bursts and gaps, stalls the
// result side, and checks every result against an in-bench table model that
// tracks the first strict current maximum and the configured lowest period.
// ----------------------------------------------------------------------------
module tb_resonance_peak_tracker;

    import ptrk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CUR_W-1:0] AMPS_1000   = 32'd4096000;
    localparam logic [PER_W-1:0] PERIOD_BOOT = 16'd3000;
    localparam int               SCAN_CYCLES = 1100;
    localparam int               CYCLE_LIMIT = 12_000_000;

    typedef enum logic [1:0] {
        STIM_FIXED,
        STIM_NEAR,
        STIM_FAULT
    } stim_kind_t;

    typedef struct {
        stim_kind_t       kind;
        logic [CUR_W-1:0] value;
        int               off;
        longint           delta;
    } stim_t;

    typedef struct packed {
        logic [PER_W-1:0]  period;
        logic [BEST_W-1:0] best;
        logic              changed;
        logic [CUR_W-1:0]  peak;
    } peak_report_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [PER_W-1:0]  lowest_period  = '0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic              action         = 1'b0;
    logic [CUR_W-1:0]  rms_current    = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [PER_W-1:0]  period;
    logic [BEST_W-1:0] best_index;
    logic              period_changed;
    logic [CUR_W-1:0]  peak_current;

    logic [CUR_W-1:0]  current_tbl [NUM_PERIODS];
    logic [IDX_W-1:0]  best_slot;
    logic [PER_W-1:0]  low_period_now;

    stim_t             stim_q [$];
    peak_report_t      peak_reports_q [$];
    stim_t             pending_item;
    peak_report_t      oldest;

    int                gap_left       = 0;
    int                burst_left     = 1;
    logic [15:0]       stall_pat      = '1;
    int                stall_left     = 0;
    int unsigned       fed_total      = 0;
    int unsigned       results_seen   = 0;
    int unsigned       mismatch_count = 0;
    int                cycle_count    = 0;

    resonance_peak_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .lowest_period  (lowest_period),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .rms_current    (rms_current),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .period         (period),
        .best_index     (best_index),
        .period_changed (period_changed),
        .peak_current   (peak_current)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic peak_report_t track_peak(input logic act,
                                                input logic [CUR_W-1:0] cur);
        peak_report_t     r;
        logic [CUR_W-1:0] top;
        logic [IDX_W-1:0] where;
        current_tbl[best_slot] = act ? 32'd1 : cur;
        top   = '0;
        where = '0;
        for (int i = 0; i < NUM_PERIODS; i++)
        begin
            if (current_tbl[i] > top)
            begin
                top   = current_tbl[i];
                where = IDX_W'(i);
            end
        end
        r.period  = PER_W'(where) + low_period_now;
        r.best    = where;
        r.changed = (where != best_slot);
        r.peak    = current_tbl[where];
        best_slot = where;
        return r;
    endfunction

    function automatic logic [CUR_W-1:0] resolve_current(input stim_t s);
        logic [IDX_W-1:0] idx;
        longint           v;
        if (s.kind != STIM_NEAR)
            return s.value;
        idx = IDX_W'(int'(best_slot) + s.off);
        v   = longint'(current_tbl[idx]) + s.delta;
        if (v < 0)
            v = 0;
        else if (v > 64'sd4294967295)
            v = 64'sd4294967295;
        return CUR_W'(v);
    endfunction

    task automatic feed(input stim_kind_t k, input logic [CUR_W-1:0] v,
                        input int off, input longint delta);
        stim_t s;
        s.kind  = k;
        s.value = v;
        s.off   = off;
        s.delta = delta;
        stim_q.push_back(s);
        fed_total++;
    endtask

    task automatic wait_drained();
        while (results_seen < fed_total)
            @(posedge clk);
    endtask

    task automatic write_lowest(input logic [PER_W-1:0] v);
        @(posedge clk);
        cfg_valid     <= 1'b1;
        lowest_period <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        low_period_now = v;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                peak_reports_q.push_back(track_peak(action, rms_current));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || stim_q.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    pending_item = stim_q.pop_front();
                    action      <= (pending_item.kind == STIM_FAULT);
                    rms_current <= resolve_current(pending_item);
                    in_valid    <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1100)
                                                                 : $urandom_range(0, 6);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_pat  = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
                stall_left = $urandom_range(16, 400);
            end
            out_ready <= stall_pat[0];
            stall_pat  = {stall_pat[0], stall_pat[15:1]};
            stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (peak_reports_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result transfer: period %0d best %0d peak %h",
                             period, best_index, peak_current);
                mismatch_count++;
            end
            else
            begin
                oldest = peak_reports_q.pop_front();
                if (period !== oldest.period || best_index !== oldest.best ||
                    period_changed !== oldest.changed || peak_current !== oldest.peak)
                begin
                    if (mismatch_count < 10)
                    begin
                        $write("mismatch (expected/actual): period %0d/%0d best %0d/%0d ",
                               oldest.period, period, oldest.best, best_index);
                        $display("changed %0b/%0b peak %h/%h",
                                 oldest.changed, period_changed, oldest.peak, peak_current);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int     sel;
        longint delta;
        for (int i = 0; i < NUM_PERIODS; i++)
            current_tbl[i] = CUR_W'(longint'(i + 1) * longint'(AMPS_1000));
        best_slot      = '0;
        low_period_now = PERIOD_BOOT;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        feed(STIM_FIXED, '0, 0, 0);
        feed(STIM_FIXED, '1, 0, 0);
        feed(STIM_FAULT, '1, 0, 0);
        feed(STIM_NEAR, '0, -1, 0);
        wait_drained();
        write_lowest('0);
        feed(STIM_NEAR, '0, 0, 1);
        feed(STIM_FIXED, '0, 0, 0);
        wait_drained();
        write_lowest('1);
        feed(STIM_FIXED, 32'd5, 0, 0);
        feed(STIM_FAULT, '0, 0, 0);
        wait_drained();
        write_lowest(16'd64512);
        feed(STIM_NEAR, '0, 0, -1);
        feed(STIM_FIXED, 32'd1, 0, 0);
        feed(STIM_NEAR, '0, 6, 0);
        feed(STIM_NEAR, '0, -1016, 0);
        feed(STIM_FIXED, 32'h5555_5555, 0, 0);
        feed(STIM_FIXED, 32'hAAAA_AAAA, 0, 0);

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_lowest(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 64512)));
            for (int n = 0; n < 90; n++)
            begin
                if (n == 45)
                    wait_drained();
                sel = $urandom_range(0, 99);
                if (sel < 50)
                begin
                    case ($urandom_range(0, 3))
                        0:       delta = 0;
                        1, 2:    delta = longint'($urandom_range(0, 6)) - 3;
                        default: delta = longint'($urandom_range(0, 8192000)) - 4096000;
                    endcase
                    feed(STIM_NEAR, '0, int'($urandom_range(0, 8)) - 4, delta);
                end
                else if (sel < 65)
                    feed(STIM_FAULT, $urandom, 0, 0);
                else if (sel < 82)
                    feed(STIM_FIXED, '0, 0, 0);
                else
                    feed(STIM_FIXED, ($urandom_range(0, 9) == 0) ? '1 : $urandom, 0, 0);
            end
        end

        wait_drained();
        write_lowest(16'($urandom));
        feed(STIM_FAULT, '1, 0, 0);
        feed(STIM_FIXED, '0, 0, 0);
        feed(STIM_NEAR, '0, 0, 0);
        feed(STIM_FIXED, $urandom, 0, 0);
        feed(STIM_FAULT, $urandom, 0, 0);

        wait_drained();
        repeat (SCAN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && peak_reports_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
